>>> hw/rtl/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared widths, constants and sequencer states of the coin composition counter.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam int COIN_W   = 20;
  localparam int WAY_W    = 30;
  localparam int TARGET_W = 12;
  localparam int CMP_W    = COIN_W + 1;

  localparam int MAX_COINS_DEF = 128;
  localparam int MAX_SUM_DEF   = 4095;

  localparam logic [WAY_W-1:0]    WAY_MODULUS  = 30'd1000000007;
  localparam logic [TARGET_W-1:0] TARGET_RESET = 12'd1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_HERE_RD,
    ST_HERE_WAIT,
    ST_COINS,
    ST_DRAIN,
    ST_FINAL_RD,
    ST_FINAL_WAIT,
    ST_RESULT
  } ccc_state_t;

endpackage

>>> hw/rtl/ccc_in_if.sv
// ----------------------------------------------------------------------------
// ccc_in_if
// Coin channel: one coin value per transaction, with the end-of-batch mark.
// ----------------------------------------------------------------------------
interface ccc_in_if;
  logic                        valid;
  logic                        ready;
  logic [ccc_pkg::COIN_W-1:0]  coin_value;
  logic                        last_coin;

  modport source (output valid, coin_value, last_coin, input ready);
  modport sink   (input valid, coin_value, last_coin, output ready);
endinterface

>>> hw/rtl/ccc_out_if.sv
// ----------------------------------------------------------------------------
// ccc_out_if
// Result channel: way count and overflow flag, one transaction per batch.
// ----------------------------------------------------------------------------
interface ccc_out_if;
  logic                       valid;
  logic                       ready;
  logic [ccc_pkg::WAY_W-1:0]  way_count;
  logic                       coin_overflow;

  modport source (output valid, way_count, coin_overflow, input ready);
  modport sink   (input valid, way_count, coin_overflow, output ready);
endinterface

>>> hw/rtl/ccc_ram.sv
// ----------------------------------------------------------------------------
// ccc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module ccc_ram #(
  parameter  int WIDTH = ccc_pkg::WAY_W,
  parameter  int DEPTH = ccc_pkg::MAX_SUM_DEF + 1,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ccc_ways_update.sv
// ----------------------------------------------------------------------------
// ccc_ways_update
// Read-modify-write data path of the ways table: forward the previous write
// over a stale read, then add the current count modulo the prime.
// ----------------------------------------------------------------------------
module ccc_ways_update #(
  parameter int SUM_W = 12
) (
  input  logic [ccc_pkg::WAY_W-1:0] rd_data,
  input  logic [SUM_W-1:0]          rd_addr,
  input  logic                      fwd_valid,
  input  logic [SUM_W-1:0]          fwd_addr,
  input  logic [ccc_pkg::WAY_W-1:0] fwd_data,
  input  logic [ccc_pkg::WAY_W-1:0] here,
  output logic [ccc_pkg::WAY_W-1:0] upd
);

  logic [ccc_pkg::WAY_W-1:0] old;
  logic [ccc_pkg::WAY_W:0]   sum;
  logic [ccc_pkg::WAY_W:0]   modulus_wide;

  assign modulus_wide = {1'b0, ccc_pkg::WAY_MODULUS};

  always_comb begin
    // the RAM read returned the value from before the last write
    old = (fwd_valid && (fwd_addr == rd_addr)) ? fwd_data : rd_data;
    sum = {1'b0, old} + {1'b0, here};
    if (sum >= modulus_wide) begin
      upd = ccc_pkg::WAY_W'(sum - modulus_wide);
    end else begin
      upd = sum[ccc_pkg::WAY_W-1:0];
    end
  end

endmodule

>>> hw/rtl/coin_composition_counter.sv
// ----------------------------------------------------------------------------
// coin_composition_counter
// Counts ordered coin sequences that reach target_sum, modulo 1000000007.
// Coins are taken one per cycle while loading, and nonzero ones are stored in
// the coin RAM. The transaction with last_coin set starts the count, and the
// input stays stalled until the result is written to the output register. The
// count runs over the ways RAM: a clearing sweep over sums 0 to goal, then for
// each sum a fetch of its count and, for a nonzero count, a pass over the
// stored coins and a drain of the read-modify-write pipeline, then a fetch of
// the answer at goal. A zero target gives a count of 0 at once. A target above
// MAX_SUM is saturated to MAX_SUM. Coins past MAX_COINS are dropped and
// flagged.
// ----------------------------------------------------------------------------
module coin_composition_counter #(
  parameter int MAX_COINS = ccc_pkg::MAX_COINS_DEF,
  parameter int MAX_SUM   = ccc_pkg::MAX_SUM_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  ccc_in_if.sink                       coin_in,
  ccc_out_if.source                    result_out,
  input  logic                         cfg_we,
  input  logic [ccc_pkg::TARGET_W-1:0] cfg_wdata
);

  localparam int SUM_W   = $clog2(MAX_SUM + 1);
  localparam int COIN_AW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int CNT_W   = $clog2(MAX_COINS + 1);
  localparam int CMP_W   = ccc_pkg::CMP_W;
  localparam int WAY_W   = ccc_pkg::WAY_W;

  ccc_pkg::ccc_state_t state, state_next;

  logic [ccc_pkg::TARGET_W-1:0] target_sum;
  logic [CNT_W-1:0]             coins_loaded;
  logic                         overflow_seen;
  logic                         ovf_hold;
  logic                         zero_goal;
  logic [SUM_W-1:0]             goal;
  logic [SUM_W-1:0]             s_idx;
  logic [COIN_AW-1:0]           k_idx;
  logic [WAY_W-1:0]             here;

  logic                         p1_valid;
  logic                         p2_valid;
  logic [SUM_W-1:0]             p2_addr;
  logic                         fwd_valid;
  logic [SUM_W-1:0]             fwd_addr;
  logic [WAY_W-1:0]             fwd_data;

  logic                         out_valid;
  logic [WAY_W-1:0]             out_count;
  logic                         out_ovf;

  logic                         coin_re;
  logic [ccc_pkg::COIN_W-1:0]   coin_rdata;

  logic                         ways_we;
  logic [SUM_W-1:0]             ways_waddr;
  logic [WAY_W-1:0]             ways_wdata;
  logic                         ways_re;
  logic [SUM_W-1:0]             ways_raddr;
  logic [WAY_W-1:0]             ways_rdata;
  logic [WAY_W-1:0]             upd;

  logic                         in_ready;
  logic                         clr_we;
  logic                         here_re;
  logic                         fin_re;
  logic                         out_load;

  logic                         in_fire;
  logic                         batch_end;
  logic                         room;
  logic                         coin_store;
  logic                         coin_drop;
  logic [CMP_W-1:0]             target_wide;
  logic [SUM_W-1:0]             goal_sat;
  logic                         s_last;
  logic                         k_last;
  logic                         here_done;
  logic                         drained;
  logic                         coin_fit;
  logic                         s1_go;
  logic [SUM_W-1:0]             t_addr;
  logic [WAY_W-1:0]             clr_data;

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  assign in_fire    = coin_in.valid && coin_in.ready;
  assign batch_end  = in_fire && coin_in.last_coin;
  assign room       = coins_loaded < CNT_W'(MAX_COINS);
  assign coin_store = in_fire && (coin_in.coin_value != '0) && room;
  assign coin_drop  = in_fire && (coin_in.coin_value != '0) && !room;

  assign target_wide = CMP_W'(target_sum);
  assign goal_sat    = (target_wide > CMP_W'(MAX_SUM)) ? SUM_W'(MAX_SUM)
                                                       : target_wide[SUM_W-1:0];

  assign s_last    = (s_idx == goal);
  assign k_last    = ((CNT_W'(k_idx) + CNT_W'(1)) == coins_loaded);
  assign here_done = (ways_rdata == '0) || (coins_loaded == '0);
  assign drained   = !p1_valid && !p2_valid;

  // --------------------------------------------------------------------------
  // Update pipeline: coin read, ways read at sum+coin, add and write back
  // --------------------------------------------------------------------------
  assign coin_fit = CMP_W'(coin_rdata) <= (CMP_W'(goal) - CMP_W'(s_idx));
  assign t_addr   = s_idx + coin_rdata[SUM_W-1:0];
  assign s1_go    = p1_valid && coin_fit;
  assign clr_data = (s_idx == '0) ? WAY_W'(1) : '0;

  assign ways_we    = clr_we || p2_valid;
  assign ways_waddr = p2_valid ? p2_addr : s_idx;
  assign ways_wdata = p2_valid ? upd : clr_data;
  assign ways_re    = here_re || fin_re || s1_go;
  assign ways_raddr = s1_go ? t_addr : (fin_re ? goal : s_idx);

  ccc_ram #(
    .WIDTH (ccc_pkg::COIN_W),
    .DEPTH (MAX_COINS)
  ) u_coin_ram (
    .clk   (clk),
    .we    (coin_store),
    .waddr (coins_loaded[COIN_AW-1:0]),
    .wdata (coin_in.coin_value),
    .re    (coin_re),
    .raddr (k_idx),
    .rdata (coin_rdata)
  );

  ccc_ram #(
    .WIDTH (WAY_W),
    .DEPTH (MAX_SUM + 1)
  ) u_ways_ram (
    .clk   (clk),
    .we    (ways_we),
    .waddr (ways_waddr),
    .wdata (ways_wdata),
    .re    (ways_re),
    .raddr (ways_raddr),
    .rdata (ways_rdata)
  );

  ccc_ways_update #(
    .SUM_W (SUM_W)
  ) u_ways_update (
    .rd_data   (ways_rdata),
    .rd_addr   (p2_addr),
    .fwd_valid (fwd_valid),
    .fwd_addr  (fwd_addr),
    .fwd_data  (fwd_data),
    .here      (here),
    .upd       (upd)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ccc_pkg::ST_LOAD: begin
        if (batch_end) begin
          state_next = (target_sum == '0) ? ccc_pkg::ST_RESULT : ccc_pkg::ST_CLEAR;
        end
      end
      ccc_pkg::ST_CLEAR: begin
        if (s_last) begin
          state_next = ccc_pkg::ST_HERE_RD;
        end
      end
      ccc_pkg::ST_HERE_RD: begin
        state_next = ccc_pkg::ST_HERE_WAIT;
      end
      ccc_pkg::ST_HERE_WAIT: begin
        if (here_done) begin
          state_next = s_last ? ccc_pkg::ST_FINAL_RD : ccc_pkg::ST_HERE_RD;
        end else begin
          state_next = ccc_pkg::ST_COINS;
        end
      end
      ccc_pkg::ST_COINS: begin
        if (k_last) begin
          state_next = ccc_pkg::ST_DRAIN;
        end
      end
      ccc_pkg::ST_DRAIN: begin
        if (drained) begin
          state_next = s_last ? ccc_pkg::ST_FINAL_RD : ccc_pkg::ST_HERE_RD;
        end
      end
      ccc_pkg::ST_FINAL_RD: begin
        state_next = ccc_pkg::ST_FINAL_WAIT;
      end
      ccc_pkg::ST_FINAL_WAIT: begin
        state_next = ccc_pkg::ST_RESULT;
      end
      ccc_pkg::ST_RESULT: begin
        if (out_load) begin
          state_next = ccc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = ccc_pkg::ST_LOAD;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    clr_we   = 1'b0;
    here_re  = 1'b0;
    fin_re   = 1'b0;
    coin_re  = 1'b0;
    out_load = 1'b0;
    case (state)
      ccc_pkg::ST_LOAD:     in_ready = 1'b1;
      ccc_pkg::ST_CLEAR:    clr_we   = 1'b1;
      ccc_pkg::ST_HERE_RD:  here_re  = 1'b1;
      ccc_pkg::ST_COINS:    coin_re  = 1'b1;
      ccc_pkg::ST_FINAL_RD: fin_re   = 1'b1;
      ccc_pkg::ST_RESULT:   out_load = !out_valid || result_out.ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign coin_in.ready = in_ready;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ccc_pkg::ST_LOAD;
      target_sum    <= ccc_pkg::TARGET_RESET;
      coins_loaded  <= '0;
      overflow_seen <= 1'b0;
      p1_valid      <= 1'b0;
      p2_valid      <= 1'b0;
      fwd_valid     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      p1_valid  <= coin_re;
      p2_valid  <= s1_go;
      fwd_valid <= p2_valid;

      if (cfg_we) begin
        target_sum <= cfg_wdata;
      end

      if (coin_store) begin
        coins_loaded <= coins_loaded + CNT_W'(1);
      end else if (out_load) begin
        coins_loaded <= '0;
      end

      if (batch_end) begin
        overflow_seen <= 1'b0;
      end else if (coin_drop) begin
        overflow_seen <= 1'b1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (batch_end) begin
      ovf_hold  <= overflow_seen || coin_drop;
      zero_goal <= (target_sum == '0);
      goal      <= goal_sat;
    end

    case (state)
      ccc_pkg::ST_LOAD: begin
        s_idx <= '0;
      end
      ccc_pkg::ST_CLEAR: begin
        s_idx <= s_last ? '0 : s_idx + SUM_W'(1);
      end
      ccc_pkg::ST_HERE_WAIT: begin
        here  <= ways_rdata;
        k_idx <= '0;
        if (here_done && !s_last) begin
          s_idx <= s_idx + SUM_W'(1);
        end
      end
      ccc_pkg::ST_COINS: begin
        k_idx <= k_idx + COIN_AW'(1);
      end
      ccc_pkg::ST_DRAIN: begin
        if (drained && !s_last) begin
          s_idx <= s_idx + SUM_W'(1);
        end
      end
      default: begin
        s_idx <= s_idx;
      end
    endcase

    p2_addr  <= t_addr;
    fwd_addr <= p2_addr;
    fwd_data <= upd;

    if (out_load) begin
      out_count <= zero_goal ? '0 : ways_rdata;
      out_ovf   <= ovf_hold;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.way_count     = out_count;
  assign result_out.coin_overflow = out_ovf;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    p2_valid |-> (p2_addr <= goal))
    else $error("ways update beyond goal");

  a_drained_before_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == ccc_pkg::ST_HERE_RD) |-> (!p1_valid && !p2_valid))
    else $error("sum count fetched with updates in flight");

  a_coin_count_bound: assert property (@(posedge clk) disable iff (rst)
    coins_loaded <= CNT_W'(MAX_COINS))
    else $error("coin count beyond capacity");

  a_count_reduced: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> (result_out.way_count < ccc_pkg::WAY_MODULUS))
    else $error("way count not reduced");

endmodule

>>> tb/tb_coin_composition_counter.sv
// ----------------------------------------------------------------------------
// tb_coin_composition_counter
// Self-checking bench: streams batches of coins under several targets, counts
// ordered compositions in a local predictor and checks every result in order.
// ----------------------------------------------------------------------------
module tb_coin_composition_counter;

  typedef struct packed {
    logic [ccc_pkg::COIN_W-1:0] value;
    logic                       last;
  } coin_item_t;

  typedef struct packed {
    logic [ccc_pkg::WAY_W-1:0] way_count;
    logic                      coin_overflow;
  } batch_result_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [ccc_pkg::TARGET_W-1:0] cfg_wdata;

  ccc_in_if  coin_in ();
  ccc_out_if result_out ();

  coin_composition_counter u_dut (
    .clk        (clk),
    .rst        (rst),
    .coin_in    (coin_in),
    .result_out (result_out),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Predictor state
  logic [ccc_pkg::COIN_W-1:0] coin_store [ccc_pkg::MAX_COINS_DEF];
  int unsigned       stored_coins = 0;
  bit                coin_dropped = 1'b0;
  int unsigned       goal_shadow  = 32'(ccc_pkg::TARGET_RESET);
  int unsigned       sum_ways [ccc_pkg::MAX_SUM_DEF+1];

  coin_item_t    coin_q [$];
  batch_result_t pending_counts [$];
  coin_item_t    head_item;
  batch_result_t oldest;

  logic        coin_taken      = 1'b0;
  int unsigned send_gap        = 0;
  int unsigned stall_left      = 0;
  bit          quiet           = 1'b0;
  int unsigned mismatch_count  = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [ccc_pkg::WAY_W-1:0] count_orders(int unsigned goal);
    int unsigned here, t, v;
    if (goal == 0) return '0;
    if (goal > ccc_pkg::MAX_SUM_DEF) goal = ccc_pkg::MAX_SUM_DEF;
    for (int s = 0; s <= goal; s++) sum_ways[s] = 0;
    sum_ways[0] = 1;
    for (int s = 0; s <= goal; s++) begin
      here = sum_ways[s];
      if (here == 0) continue;
      for (int k = 0; k < stored_coins; k++) begin
        if (coin_store[k] <= goal - s) begin
          t = s + coin_store[k];
          v = sum_ways[t] + here;
          if (v >= ccc_pkg::WAY_MODULUS) v -= ccc_pkg::WAY_MODULUS;
          sum_ways[t] = v;
        end
      end
    end
    return sum_ways[goal][ccc_pkg::WAY_W-1:0];
  endfunction

  function automatic void take_coin(logic [ccc_pkg::COIN_W-1:0] value, logic last);
    batch_result_t r;
    if (value != '0) begin
      if (stored_coins < ccc_pkg::MAX_COINS_DEF) begin
        coin_store[stored_coins] = value;
        stored_coins++;
      end else begin
        coin_dropped = 1'b1;
      end
    end
    if (last) begin
      r.way_count     = count_orders(goal_shadow);
      r.coin_overflow = coin_dropped;
      pending_counts.insert(pending_counts.size(), r);
      stored_coins = 0;
      coin_dropped = 1'b0;
    end
  endfunction

  // Monitor: predict on accepted coins, check accepted results in order
  always @(posedge clk) begin
    coin_taken <= coin_in.valid && coin_in.ready && !rst;
    if (!rst) begin
      if (coin_in.valid && coin_in.ready)
        take_coin(coin_in.coin_value, coin_in.last_coin);
      if (result_out.valid && result_out.ready) begin
        if (pending_counts.size() == 0) begin
          $display("%0t: unexpected result way_count %0d coin_overflow %0b", $time,
                   result_out.way_count, result_out.coin_overflow);
          mismatch_count++;
        end else begin
          oldest = pending_counts.pop_front();
          if (result_out.way_count !== oldest.way_count) begin
            $display("%0t: way_count expected %0d, actual %0d", $time,
                     oldest.way_count, result_out.way_count);
            mismatch_count++;
          end
          if (result_out.coin_overflow !== oldest.coin_overflow) begin
            $display("%0t: coin_overflow expected %0b, actual %0b", $time,
                     oldest.coin_overflow, result_out.coin_overflow);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Coin driver: advance only once the current transaction has gone through
  always @(negedge clk) begin
    if (rst) begin
      coin_in.valid      <= 1'b0;
      coin_in.coin_value <= '0;
      coin_in.last_coin  <= 1'b0;
    end else if (!coin_in.valid || coin_taken) begin
      if (send_gap != 0) begin
        send_gap      <= send_gap - 1;
        coin_in.valid <= 1'b0;
      end else if (coin_q.size() != 0) begin
        head_item           = coin_q.pop_front();
        coin_in.valid      <= 1'b1;
        coin_in.coin_value <= head_item.value;
        coin_in.last_coin  <= head_item.last;
        if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 16);
      end else begin
        coin_in.valid <= 1'b0;
      end
    end
  end

  // Result sink: stall in bursts
  always @(negedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left       <= stall_left - 1;
      result_out.ready <= 1'b0;
    end else begin
      result_out.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 16);
    end
  end

  task automatic queue_coin(input logic [ccc_pkg::COIN_W-1:0] value, input logic last);
    coin_item_t item;
    item.value = value;
    item.last  = last;
    coin_q.insert(coin_q.size(), item);
  endtask

  task automatic set_target(input logic [ccc_pkg::TARGET_W-1:0] value);
    @(negedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= value;
    goal_shadow  = 32'(value);
    @(negedge clk);
    cfg_we      <= 1'b0;
  endtask

  // Hold until every coin is taken and every count has come back
  task automatic wait_drained();
    while (coin_q.size() != 0 || coin_in.valid || pending_counts.size() != 0)
      @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [ccc_pkg::COIN_W-1:0] pick_coin(int unsigned goal);
    case ($urandom_range(0, 9)) inside
      [0:5]:   return ccc_pkg::COIN_W'($urandom_range(1, (goal == 0) ? 1 : goal));
      [6:7]:   return ccc_pkg::COIN_W'($urandom_range(1, (1 << ccc_pkg::COIN_W) - 1));
      8:       return ccc_pkg::COIN_W'($urandom_range(goal + 1, goal + 64));
      default: return ($urandom_range(0, 3) == 0) ? '0 :
                      ccc_pkg::COIN_W'($urandom_range(1, (1 << ccc_pkg::COIN_W) - 1));
    endcase
  endfunction

  task automatic fill_phase(input int unsigned goal, input int unsigned budget,
                            input int unsigned max_len, input bit flood);
    int unsigned left, len;
    left = budget;
    // overrun the coin table once, with the last coin landing on either side
    if (flood) begin
      len = $urandom_range(126, 136);
      for (int i = 0; i < len; i++) queue_coin(pick_coin(goal), i == len - 1);
    end
    while (left > 0) begin
      len = $urandom_range(1, max_len);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) queue_coin(pick_coin(goal), i == len - 1);
      left -= len;
    end
  endtask

  initial begin
    int unsigned goal;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset target of one
    queue_coin(20'd1, 1'b1);
    queue_coin(20'd2, 1'b0);
    queue_coin(20'd1, 1'b1);
    queue_coin(20'd0, 1'b1);          // batch holding no coin at all
    wait_drained();

    // Zero target
    set_target(12'd0);
    queue_coin(20'd1, 1'b0);
    queue_coin(20'd5, 1'b1);
    wait_drained();

    // Largest target, dense and sparse coin sets
    set_target(12'hFFF);
    queue_coin(20'd1, 1'b0);
    queue_coin(20'd2, 1'b0);
    queue_coin(20'd3, 1'b1);
    queue_coin(20'hFFFFF, 1'b0);
    queue_coin(20'd4095, 1'b0);
    queue_coin(20'd2048, 1'b1);
    wait_drained();

    // Coins above the target, a zero coin inside a batch, repeated values
    set_target(12'd10);
    queue_coin(20'd1, 1'b0);
    queue_coin(20'd2, 1'b0);
    queue_coin(20'h80000, 1'b0);
    queue_coin(20'd0, 1'b0);
    queue_coin(20'd10, 1'b1);
    queue_coin(20'd3, 1'b0);
    queue_coin(20'd3, 1'b0);
    queue_coin(20'd4, 1'b1);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      if (p == 8) quiet = 1'b1;
      if (p == 4) begin
        goal = $urandom_range(2048, 4095);
        set_target(ccc_pkg::TARGET_W'(goal));
        fill_phase(goal, 4, 2, 1'b0);
      end else if (p == 2 || p == 6) begin
        goal = $urandom_range(64, 300);
        set_target(ccc_pkg::TARGET_W'(goal));
        fill_phase(goal, 120, 6, 1'b0);
      end else begin
        goal = $urandom_range(1, 40);
        set_target(ccc_pkg::TARGET_W'(goal));
        fill_phase(goal, 135, 8, p == 1 || p == 5);
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(5_000_000 * 10);
    $display("tb: failure");
    $finish;
  end

endmodule

>>> coin_composition_counter.f
hw/rtl/ccc_pkg.sv
hw/rtl/ccc_in_if.sv
hw/rtl/ccc_out_if.sv
hw/rtl/ccc_ram.sv
hw/rtl/ccc_ways_update.sv
hw/rtl/coin_composition_counter.sv
tb/tb_coin_composition_counter.sv
